/* src/bap_pkg.sv */
// Package for the block average pixelate unit.
// Register and state codes, field widths, a shared struct; depends on nothing.
`timescale 1ns / 1ps
package bap_pkg;
  localparam int SumW = 20;
  localparam int EntryW = 4 * SumW;

  // Patch and block limits; the port and counter widths are sized for these.
  localparam int MaxWidth = 4096;
  localparam int MaxBlock = 64;
  localparam int MinBlock = 8;

  typedef enum logic [1:0] {
    REG_BLOCK_SIZE   = 2'd0,
    REG_PATCH_WIDTH  = 2'd1,
    REG_PATCH_HEIGHT = 2'd2,
    REG_NONE         = 2'd3
  } reg_index_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_READ = 2'd1,
    ST_DIV  = 2'd2,
    ST_OUT  = 2'd3
  } state_t;

  // Item handed from the accumulate stage to the divider.
  typedef struct packed {
    logic [8:0]        block_col;
    logic [8:0]        block_row;
    logic [EntryW-1:0] sums;
    logic [12:0]       count;
    logic              final_block;
  } div_req_t;
endpackage

/* src/block_average_pixelate_unit.sv */
// Top level of the block average pixelate unit.
// Uses bap_pkg, bap_ram (column sum store) and bap_div (average divider).
`timescale 1ns / 1ps
// Usage: configuration writes on cfg_valid/cfg_ready set block_size (index 0),
// patch_width (1) and patch_height (2); any known write restarts the patch.
// Pixels enter on the s_axis channel in raster order, one transaction each.
// Each pixel reads its block-column entry from the sum store (registered
// read), adds and writes back before the next pixel is taken.
// A pixel that closes a block waits until the output register is free, then
// runs the shared divider (20 quotient steps). The result is registered on
// m_axis as the divider finishes, and the unit then takes the next pixel;
// tlast marks the patch's last block. A result waiting on m_axis does not
// stop the next pixel, but a second closing pixel waits until the first is
// taken.
// Reset restores default registers and zero positions; the sum store holds
// no reset state, every entry is rewritten by its block's first pixel.
// A stalled receiver holds the result; a pending cfg_valid also stalls input.
module block_average_pixelate_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: red_in[7:0], green_in[15:8], blue_in[23:16], alpha_in[31:24]
  input  logic [31:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: block_col[8:0], block_row[17:9], avg_red[25:18], avg_green[33:26],
  // avg_blue[41:34], avg_alpha[49:42], zero fill[55:50]
  output logic [55:0] m_axis_tdata,
  output logic        m_axis_tlast
);
  localparam int Depth = bap_pkg::MaxWidth / bap_pkg::MinBlock;
  localparam int AW = $clog2(Depth);
  localparam int SW = bap_pkg::SumW;

  logic [6:0]  block_size;
  logic [12:0] patch_width, patch_height;
  logic [12:0] x_pos, y_pos;
  logic [6:0]  cib, rib;
  logic [8:0]  cur_col, brow;
  logic [31:0] pix;
  bap_pkg::state_t state, state_next;

  logic [bap_pkg::EntryW-1:0] rd, wd;
  logic  we, first_px, row_end, col_end, blk_r, blk_b, closes;
  bap_pkg::div_req_t req;
  logic  dbusy, ddone;
  logic [31:0] quot;
  logic [8:0]  o_col, o_row;
  logic        o_fin;

  bap_ram #(.Width(bap_pkg::EntryW), .Depth(Depth)) u_sums (
    .clk(clk), .we(we), .waddr(cur_col[AW-1:0]), .wdata(wd),
    .raddr(cur_col[AW-1:0]), .rdata(rd)
  );

  assign row_end  = (x_pos + 13'd1) >= patch_width;
  assign col_end  = (y_pos + 13'd1) >= patch_height;
  assign blk_r    = row_end || ({6'd0, cib} + 13'd1) >= {6'd0, block_size};
  assign blk_b    = col_end || ({6'd0, rib} + 13'd1) >= {6'd0, block_size};
  assign closes   = blk_r && blk_b;
  assign first_px = (cib == 7'd0) && (rib == 7'd0);

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      wd[c*SW +: SW] = first_px ? {12'd0, pix[c*8 +: 8]}
                                : rd[c*SW +: SW] + {12'd0, pix[c*8 +: 8]};
    end
  end

  assign cfg_ready     = (state == bap_pkg::ST_IDLE);
  assign s_axis_tready = (state == bap_pkg::ST_IDLE) && !cfg_valid;
  assign we            = (state == bap_pkg::ST_READ);

  // Sequencer for one pixel.
  always_comb begin
    state_next = state;
    unique case (state)
      bap_pkg::ST_IDLE: if (s_axis_tvalid && s_axis_tready) state_next = bap_pkg::ST_READ;
      bap_pkg::ST_READ: state_next = closes ? bap_pkg::ST_OUT : bap_pkg::ST_IDLE;
      bap_pkg::ST_OUT:  if (!m_axis_tvalid || m_axis_tready) state_next = bap_pkg::ST_DIV;
      bap_pkg::ST_DIV:  if (ddone) state_next = bap_pkg::ST_IDLE;
      default:          state_next = bap_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= bap_pkg::ST_IDLE;
    else     state <= state_next;
  end

  // Configuration, positions and request capture.
  always_ff @(posedge clk) begin
    if (rst) begin
      block_size <= 7'd8;
      patch_width <= 13'd4096;
      patch_height <= 13'd4096;
      x_pos <= '0; y_pos <= '0; cib <= '0; rib <= '0; cur_col <= '0; brow <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        bap_pkg::REG_BLOCK_SIZE:
          block_size <= (cfg_data[6:0] < 7'(bap_pkg::MinBlock)) ? 7'(bap_pkg::MinBlock) :
                        ({1'b0, cfg_data[6:0]} > 8'(bap_pkg::MaxBlock)) ?
                        7'(bap_pkg::MaxBlock) : cfg_data[6:0];
        bap_pkg::REG_PATCH_WIDTH:
          patch_width <= (cfg_data == 13'd0) ? 13'd1 :
                         (cfg_data > 13'(bap_pkg::MaxWidth)) ? 13'(bap_pkg::MaxWidth) :
                         cfg_data;
        bap_pkg::REG_PATCH_HEIGHT:
          patch_height <= (cfg_data == 13'd0) ? 13'd1 :
                          (cfg_data > 13'(bap_pkg::MaxWidth)) ? 13'(bap_pkg::MaxWidth) :
                          cfg_data;
        default: ;
      endcase
      if (cfg_index != bap_pkg::REG_NONE) begin
        x_pos <= '0; y_pos <= '0; cib <= '0; rib <= '0; cur_col <= '0; brow <= '0;
      end
    end else if (state == bap_pkg::ST_READ) begin
      req.sums        <= wd;
      req.count       <= 13'(({6'd0, cib} + 13'd1) * ({6'd0, rib} + 13'd1));
      req.block_col   <= cur_col;
      req.block_row   <= brow;
      req.final_block <= row_end && col_end;
      if (row_end) begin
        x_pos <= '0; cib <= '0; cur_col <= '0;
        if (col_end) begin
          y_pos <= '0; rib <= '0; brow <= '0;
        end else begin
          y_pos <= y_pos + 13'd1;
          if (({6'd0, rib} + 13'd1) >= {6'd0, block_size}) begin
            rib <= '0;
            brow <= brow + 9'd1;
          end else begin
            rib <= rib + 7'd1;
          end
        end
      end else begin
        x_pos <= x_pos + 13'd1;
        if (({6'd0, cib} + 13'd1) >= {6'd0, block_size}) begin
          cib <= '0;
          cur_col <= cur_col + 9'd1;
        end else begin
          cib <= cib + 7'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) pix <= s_axis_tdata;
  end

  bap_div u_div (
    .clk(clk), .rst(rst),
    .start(state == bap_pkg::ST_OUT && (!m_axis_tvalid || m_axis_tready)),
    .req(req), .busy(dbusy), .done(ddone), .quot(quot)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (ddone) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
    if (state == bap_pkg::ST_OUT && (!m_axis_tvalid || m_axis_tready)) begin
      o_col <= req.block_col;
      o_row <= req.block_row;
      o_fin <= req.final_block;
    end
  end

  assign m_axis_tdata = {6'd0, quot[31:24], quot[23:16], quot[15:8], quot[7:0], o_row, o_col};
  assign m_axis_tlast = o_fin;

`ifndef ASSERT_OFF
  a_div_only_in_div: assert property (@(posedge clk) disable iff (rst)
    dbusy |-> state == bap_pkg::ST_DIV) else $error("divider busy outside divide");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    ddone |-> !m_axis_tvalid || m_axis_tready) else $error("result overwritten");
  a_write_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> we) else $error("pixel not written back");
`endif
endmodule

/* src/bap_ram.sv */
// Generic single-port-write, single-read RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps
module bap_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* src/bap_div.sv */
// Restoring divider that divides four channel sums by one pixel count.
// One quotient bit per cycle for all four channels; uses bap_pkg.
`timescale 1ns / 1ps
module bap_div (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  bap_pkg::div_req_t req,
  output logic              busy,
  output logic              done,
  output logic [31:0]       quot
);
  localparam int SW = bap_pkg::SumW;

  logic [SW-1:0]  rem [4];
  logic [SW-1:0]  num [4];
  logic [7:0]     q [4];
  logic [12:0]    den;
  logic [4:0]     cnt;
  logic [SW:0]    trial [4];

  // One shift-subtract step per channel.
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      trial[c] = {rem[c], num[c][SW-1]} - {8'd0, den};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 5'(SW);
        den  <= req.count;
        for (int c = 0; c < 4; c++) begin
          num[c] <= req.sums[c*SW +: SW];
          rem[c] <= '0;
          q[c]   <= '0;
        end
      end else if (busy) begin
        for (int c = 0; c < 4; c++) begin
          num[c] <= {num[c][SW-2:0], 1'b0};
          if (!trial[c][SW]) begin
            rem[c] <= trial[c][SW-1:0];
            q[c]   <= {q[c][6:0], 1'b1};
          end else begin
            rem[c] <= {rem[c][SW-2:0], num[c][SW-1]};
            q[c]   <= {q[c][6:0], 1'b0};
          end
        end
        cnt <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quot = {q[3], q[2], q[1], q[0]};

`ifndef ASSERT_OFF
  a_no_start_busy: assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("divider started while busy");
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy)) else $error("done without work");
  a_den_nonzero: assert property (@(posedge clk) disable iff (rst)
    start |-> req.count != 13'd0) else $error("zero pixel count");
`endif
endmodule

/* tb/bap_checker.sv */
// Checker for the block average pixelate unit: watches the configuration,
// pixel and block channels, predicts block averages and compares them.
// Depends on bap_pkg for the register index codes.
`timescale 1ns / 1ps
module bap_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  // tdata: red_in[7:0], green_in[15:8], blue_in[23:16], alpha_in[31:24]
  input  logic [31:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: block_col[8:0], block_row[17:9], avg_red[25:18], avg_green[33:26],
  // avg_blue[41:34], avg_alpha[49:42], zero fill[55:50]
  input  logic [55:0] m_axis_tdata,
  input  logic        m_axis_tlast,
  output int          errors,
  output int          pending,
  output int          blocks_seen
);
  typedef struct {
    logic [8:0] col;
    logic [8:0] row;
    logic [7:0] chan [4];
    logic       fin;
  } block_avg_t;

  block_avg_t avg_queue[$];

  int unsigned blk_size, pat_w, pat_h;
  int unsigned x_pos, y_pos, col_in, row_in, blk_col;
  logic [19:0] col_sums [512][4];

  function automatic int unsigned clamp(int unsigned v, int unsigned lo, int unsigned hi);
    return (v < lo) ? lo : (v > hi) ? hi : v;
  endfunction

  // Accumulate one pixel and queue the block average it closes, if any.
  task automatic add_pixel(logic [31:0] px);
    int unsigned slot, cnt, brow;
    bit row_end, col_end, at_right, at_bottom;
    block_avg_t e;
    slot = blk_col % 512;
    row_end = x_pos + 1 >= pat_w;
    col_end = y_pos + 1 >= pat_h;
    at_right = row_end || col_in + 1 >= blk_size;
    at_bottom = col_end || row_in + 1 >= blk_size;
    for (int c = 0; c < 4; c++) begin
      if (col_in == 0 && row_in == 0) col_sums[slot][c] = px[8*c +: 8];
      else col_sums[slot][c] = col_sums[slot][c] + px[8*c +: 8];
    end
    if (at_right && at_bottom) begin
      cnt = (col_in + 1) * (row_in + 1);
      brow = (y_pos >= row_in) ? (y_pos - row_in) / blk_size : 0;
      e.col = blk_col[8:0];
      e.row = brow[8:0];
      for (int c = 0; c < 4; c++) e.chan[c] = 8'(col_sums[slot][c] / cnt);
      e.fin = row_end && col_end;
      avg_queue.push_back(e);
    end
    if (row_end) begin
      x_pos = 0;
      col_in = 0;
      blk_col = 0;
      if (col_end) begin
        y_pos = 0;
        row_in = 0;
      end else begin
        y_pos++;
        row_in = (row_in + 1 >= blk_size) ? 0 : row_in + 1;
      end
    end else begin
      x_pos++;
      if (col_in + 1 >= blk_size) begin
        col_in = 0;
        blk_col = (blk_col + 1) % 512;
      end else begin
        col_in++;
      end
    end
  endtask

  task automatic note_mismatch(string what, int exp_v, int act_v);
    errors++;
    if (errors <= 10)
      $display("mismatch on %s: expected %0d, got %0d (block %0d)",
               what, exp_v, act_v, blocks_seen);
  endtask

  always @(posedge clk) begin
    block_avg_t e;
    if (rst) begin
      blk_size = 8;
      pat_w = 4096;
      pat_h = 4096;
      x_pos = 0; y_pos = 0; col_in = 0; row_in = 0; blk_col = 0;
      avg_queue.delete();
      errors = 0;
      blocks_seen = 0;
    end else begin
      // A known register write sets the value and restarts the patch.
      if (cfg_valid && cfg_ready &&
          bap_pkg::reg_index_t'(cfg_index) != bap_pkg::REG_NONE) begin
        case (bap_pkg::reg_index_t'(cfg_index))
          bap_pkg::REG_BLOCK_SIZE:  blk_size = clamp(cfg_data[6:0], 8, 64);
          bap_pkg::REG_PATCH_WIDTH: pat_w = clamp(cfg_data, 1, 4096);
          default:                  pat_h = clamp(cfg_data, 1, 4096);
        endcase
        x_pos = 0; y_pos = 0; col_in = 0; row_in = 0; blk_col = 0;
      end
      // Compare a finished block before queuing new ones from this cycle.
      if (m_axis_tvalid && m_axis_tready) begin
        if (avg_queue.size() == 0) begin
          note_mismatch("unexpected block transaction", 0, 1);
        end else begin
          e = avg_queue.pop_front();
          if (m_axis_tdata[8:0] !== e.col) note_mismatch("block_col", e.col, m_axis_tdata[8:0]);
          if (m_axis_tdata[17:9] !== e.row) note_mismatch("block_row", e.row, m_axis_tdata[17:9]);
          for (int c = 0; c < 4; c++)
            if (m_axis_tdata[18+8*c +: 8] !== e.chan[c])
              note_mismatch($sformatf("channel %0d average", c), e.chan[c],
                            m_axis_tdata[18+8*c +: 8]);
          if (m_axis_tlast !== e.fin) note_mismatch("final_block", e.fin, m_axis_tlast);
        end
        blocks_seen++;
      end
      if (s_axis_tvalid && s_axis_tready) add_pixel(s_axis_tdata);
    end
    pending = avg_queue.size();
  end
endmodule

/* tb/tb_top.sv */
// Testbench top for the block average pixelate unit: clock, reset, stimulus
// and verdict. Depends on bap_pkg, the unit itself and bap_checker.
`timescale 1ns / 1ps
module tb_top;
  localparam int WatchLimit = 5000;
  localparam int DrainCycles = 40;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = bap_pkg::REG_NONE;
  logic [12:0] cfg_data = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;
  logic        m_axis_tlast;

  int errors, pending, blocks_seen;
  int send_idle = 0, recv_idle = 0;
  int hold_cycles = 0;
  bit hold_req = 1'b0;
  bit hold_used = 1'b0;
  int pixels_sent = 0, watch = 0;

  block_average_pixelate_unit dut (.*);

  bap_checker checker_i (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver: random stalls, plus one long hold-off on request.
  always @(negedge clk) begin
    if (hold_req && !hold_used) begin
      hold_cycles = 300;
      hold_used = 1'b1;
    end
    if (hold_cycles > 0) begin
      m_axis_tready = 1'b0;
      hold_cycles--;
    end else begin
      m_axis_tready = $urandom_range(99) >= recv_idle;
    end
  end

  // Watchdog on cycles with no transaction on any channel.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      watch = 0;
    end else if (++watch >= WatchLimit) begin
      $display("watchdog expired with %0d blocks outstanding", pending);
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic send_pixel(logic [31:0] px);
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata = px;
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    pixels_sent++;
  endtask

  // Register writes wait for the block to drain completely.
  task automatic write_reg(bap_pkg::reg_index_t idx, logic [12:0] val);
    while (pending != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_patch(logic [12:0] bs, logic [12:0] w, logic [12:0] h);
    write_reg(bap_pkg::REG_BLOCK_SIZE, bs);
    write_reg(bap_pkg::REG_PATCH_WIDTH, w);
    write_reg(bap_pkg::REG_PATCH_HEIGHT, h);
  endtask

  task automatic random_pixels(int n);
    logic [31:0] px;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(3))
        0: px = {4{$urandom_range(1) ? 8'hFF : 8'h00}};
        default: px = $urandom;
      endcase
      send_pixel(px);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: one-pixel patches with extreme values, out-of-range registers.
    set_patch(13'd0, 13'd0, 13'd1);
    send_pixel(32'h0000_0000);
    send_pixel(32'hFFFF_FFFF);
    send_pixel(32'hAAAA_AAAA);
    send_pixel(32'h5555_5555);
    write_reg(bap_pkg::REG_NONE, 13'h1FFF);
    send_pixel(32'h1234_5678);
    // Small partial patch, all white then all black.
    set_patch(13'd8, 13'd3, 13'd2);
    repeat (6) send_pixel(32'hFFFF_FFFF);
    repeat (6) send_pixel(32'h0000_0000);
    set_patch(13'd127, 13'd65, 13'd1);
    repeat (4) send_pixel(32'hFF00_FF00);

    // Phase with a slow receiver.
    send_idle = 12; recv_idle = 69;
    set_patch(13'd8, 13'd20, 13'd13);
    random_pixels(200);
    set_patch(13'd9, 13'd17, 13'd9);
    random_pixels(120);

    // Phase with a slow sender.
    send_idle = 69; recv_idle = 12;
    set_patch(13'd100, 13'd70, 13'd3);
    random_pixels(150);

    // No idling; a long receiver hold-off fills the block.
    send_idle = 0; recv_idle = 0;
    set_patch(13'd13, 13'd37, 13'd29);
    hold_req = 1'b1;
    random_pixels(200);
    set_patch(13'd8, 13'h1FFF, 13'd0);
    random_pixels(300);
    set_patch(13'd64, 13'd64, 13'd64);
    random_pixels(64);

    while (pending != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
    $display("Sent %0d pixels over nine patch settings; %0d block averages checked.",
             pixels_sent, blocks_seen);
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule
